// ===== rtl/bwp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwp_pkg
// Shared widths and types for the byte-to-word write packer.
// ----------------------------------------------------------------------------
package bwp_pkg;

  // word address width; the address wraps at this many bits
  localparam int unsigned WORD_ADDR_BITS = 24;
  localparam int unsigned HADDR_W        = 25;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned LANES          = WORD_W / BYTE_W;
  localparam int unsigned LANE_W         = $clog2(LANES);

  // stream packing of the channels, rounded up to whole bytes
  localparam int unsigned IN_FIELDS_W   = HADDR_W + BYTE_W;
  localparam int unsigned IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W  = WORD_ADDR_BITS + WORD_W + LANES;
  localparam int unsigned OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // lane code of the last lane (bits 7:0)
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);
  // enable bit of the first lane (bits 31:24)
  localparam logic [LANES-1:0]  BE_FIRST  = LANES'(1) << (LANES - 1);

  typedef logic [WORD_ADDR_BITS-1:0] word_addr_t;
  typedef logic [LANE_W-1:0]         lane_t;

  // one result word toward the memory
  typedef struct packed {
    logic              last_word;
    logic [LANES-1:0]  byte_enables;
    logic [WORD_W-1:0] word_data;
    word_addr_t        word_addr;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/bwp_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwp_packer
// Lane state of the word under assembly; merges one byte per transfer and
// flags when a word is complete.
// ----------------------------------------------------------------------------
module bwp_packer
  import bwp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,        // input transfer this cycle
  input  wire logic               first_byte,
  input  wire logic [HADDR_W-1:0] start_halfword_addr,
  input  wire logic [BYTE_W-1:0]  data_byte,
  input  wire logic               last_byte,
  output logic                    emit,
  output out_word_t               res
);

  word_addr_t        addr_r, addr_nxt;
  lane_t             lane_r, lane_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [LANES-1:0]  mask_r, mask_nxt;

  word_addr_t        addr_base;
  lane_t             lane_base;
  logic [WORD_W-1:0] word_base, word_new;
  logic [LANES-1:0]  mask_base, mask_new;

  // a first byte restarts the word and drops any pending lanes
  always_comb begin
    if (first_byte) begin
      addr_base = WORD_ADDR_BITS'(start_halfword_addr >> 1);
      lane_base = start_halfword_addr[0] ? lane_t'(LANES / 2) : '0;
      word_base = '0;
      mask_base = '0;
    end else begin
      addr_base = addr_r;
      lane_base = lane_r;
      word_base = word_r;
      mask_base = mask_r;
    end
  end

  // lane 0 is the top byte, so the shift is 8 * (last lane - lane)
  assign word_new = word_base
                  | (WORD_W'(data_byte) << {~lane_base, 3'b000});
  assign mask_new = mask_base | (BE_FIRST >> lane_base);
  assign emit     = (lane_base == LANE_LAST) || last_byte;

  assign res.word_addr    = addr_base;
  assign res.word_data    = word_new;
  assign res.byte_enables = mask_new;
  assign res.last_word    = last_byte;

  // next state: advance the address after a word, else move to next lane
  always_comb begin
    addr_nxt = addr_r;
    lane_nxt = lane_r;
    word_nxt = word_r;
    mask_nxt = mask_r;
    if (take) begin
      if (emit) begin
        addr_nxt = addr_base + word_addr_t'(1);
        lane_nxt = '0;
        word_nxt = '0;
        mask_nxt = '0;
      end else begin
        addr_nxt = addr_base;
        lane_nxt = lane_base + lane_t'(1);
        word_nxt = word_new;
        mask_nxt = mask_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      lane_r <= '0;
      word_r <= '0;
      mask_r <= '0;
    end else begin
      addr_r <= addr_nxt;
      lane_r <= lane_nxt;
      word_r <= word_nxt;
      mask_r <= mask_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/byte_to_word_write_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_to_word_write_packer
// Packs a byte stream into 32-bit memory writes with byte enables.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, with no gaps while the result side keeps
// out_tready high. A byte that completes a word (its lowest lane, or the
// byte marked tlast) puts the write into the output register, so the write
// appears on out_* in the cycle after the byte transfer; other bytes give no
// output. The single output register sets the rate: a new byte is taken
// whenever that register is empty or is being drained in the same cycle.
// The start address is in halfword units; an odd address starts in bits
// 15:8. Lanes without an enable read as zero in out_tdata.
// ----------------------------------------------------------------------------
module byte_to_word_write_packer
  import bwp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [24:0] start_halfword_addr, [32:25] data_byte, [39:33] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] first_byte
  input  wire logic [0:0]             in_tuser,
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [23:0] word_addr, [55:24] word_data, [59:56] byte_enables, [63:60] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  logic      in_xfer;
  logic      emit;
  out_word_t res;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  // byte taken when the result slot is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  bwp_packer u_packer (
    .clk                 (clk),
    .rst_n               (rst_n),
    .take                (in_xfer),
    .first_byte          (in_tuser[0]),
    .start_halfword_addr (in_tdata[HADDR_W-1:0]),
    .data_byte           (in_tdata[HADDR_W +: BYTE_W]),
    .last_byte           (in_tlast),
    .emit                (emit),
    .res                 (res)
  );

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_word_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_word_r.byte_enables,
                                    out_word_r.word_data,
                                    out_word_r.word_addr});
  assign out_tlast  = out_word_r.last_word;

endmodule
`default_nettype wire

// ===== rtl/bwp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwp_checker
// Port-level checks for the byte-to-word write packer.
// ----------------------------------------------------------------------------
module bwp_checker
  import bwp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  logic [LANES-1:0]  be;
  logic [WORD_W-1:0] wd;

  assign be = out_tdata[WORD_ADDR_BITS + WORD_W +: LANES];
  assign wd = out_tdata[WORD_ADDR_BITS +: WORD_W];

  // no write right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("write shown after reset");

  // a stalled write stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("write dropped while stalled");

  // every write enables at least one lane
  a_some_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> be != '0)
    else $error("write with no byte enabled");

  // a word that is not the last one ends in the lowest lane
  a_full_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> be[0])
    else $error("non-final write misses lowest lane");

  // lanes without an enable carry zero
  a_zero_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((be[3] || wd[31:24] == 8'h00) && (be[2] || wd[23:16] == 8'h00)
                 && (be[1] || wd[15:8] == 8'h00) && (be[0] || wd[7:0] == 8'h00)))
    else $error("disabled lane holds data");

endmodule

bind byte_to_word_write_packer bwp_checker u_bwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
